### rtl/alu8f_pkg.sv
// ----------------------------------------------------------------------------
// alu8f_pkg
// operation codes, flag bit positions and item types of the eight-bit alu
// ----------------------------------------------------------------------------
package alu8f_pkg;

   // operation codes
   typedef enum logic [2:0] {
      OP_ADD        = 3'd0,
      OP_SUBTRACT   = 3'd1,
      OP_AND        = 3'd2,
      OP_OR         = 3'd3,
      OP_XOR        = 3'd4,
      OP_SWAP       = 3'd5,
      OP_SHIFT      = 3'd6,
      OP_COMPLEMENT = 3'd7
   } op_type;

   // bit positions in the flag byte
   localparam int unsigned FLAG_Z_BIT = 7;
   localparam int unsigned FLAG_N_BIT = 6;
   localparam int unsigned FLAG_H_BIT = 5;
   localparam int unsigned FLAG_C_BIT = 4;

   typedef struct packed {
      op_type     kind;
      logic [7:0] operand_a;
      logic [7:0] operand_b;
      logic       carry_in;
      logic [7:0] flags_in;
   } req_type;

   typedef struct packed {
      logic [7:0] result;
      logic [7:0] flags_out;
   } rsp_type;

endpackage

### rtl/eight_bit_alu_with_flags.sv
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags
// eight-bit alu with z/n/h/c flags, registered in and out, one item per cycle
// ----------------------------------------------------------------------------
//
// channel   ports                 direction  handshake
// -------   --------------------  ---------  ---------------------------------
// request   start, busy, req      in         taken when start high, busy low
// response  rsp_strobe, rsp       out        one cycle, no back pressure
//
// - an item taken passes through the input register and the datapath into the
//   result register; the receiver takes it from rsp while rsp_strobe is high
// - stages: input register, then the datapath into the result register
// - a new item can be taken every cycle; busy is high only while reset is held
// - reset is synchronous and clears the valid bits of both stages
// - the receiver cannot stall, so nothing ever backs up inside the block
//
module eight_bit_alu_with_flags import alu8f_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp
);

   logic    accept;
   logic    vld1_ff;
   logic    vld1_in;
   req_type req_ff;
   rsp_type core_rsp;
   logic    vld2_ff;
   logic    vld2_in;
   rsp_type rsp_ff;

   // only reset holds items off
   assign busy   = reset;
   assign accept = start && !busy;

   // stage 1: input register
   assign vld1_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else begin
         vld1_ff <= vld1_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
   end

   // stage 2: datapath into the result register
   alu8f_core u_core (
      .op_req (req_ff),
      .op_rsp (core_rsp)
   );

   assign vld2_in = vld1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
      end else begin
         vld2_ff <= vld2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vld1_ff) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_strobe = vld2_ff;
   assign rsp        = rsp_ff;

   // every result strobe traces back to an earlier item taken
   a_strobe_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("result strobe without an item taken two cycles before");

   // an item taken always reaches the result register
   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("item taken but no result strobe two cycles later");

   // low nibble of the flag byte stays zero
   a_flags_low_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp.flags_out[3:0] == 4'd0))
      else $error("flag byte low nibble not zero");

   // complement keeps the incoming z and c bits
   a_complement_keeps_zc: assert property (@(posedge clock) disable iff (reset)
      (vld1_ff && (req_ff.kind == OP_COMPLEMENT)) |=>
         ((rsp.flags_out[FLAG_Z_BIT] == $past(req_ff.flags_in[FLAG_Z_BIT]))
          && (rsp.flags_out[FLAG_C_BIT] == $past(req_ff.flags_in[FLAG_C_BIT]))))
      else $error("complement changed z or c");

endmodule

### rtl/alu8f_core.sv
// ----------------------------------------------------------------------------
// alu8f_core
// combinational datapath: result and new flag byte for one operation
// ----------------------------------------------------------------------------
module alu8f_core import alu8f_pkg::*; (
   input  req_type op_req,
   output rsp_type op_rsp
);

   logic [8:0] sum9;
   logic [4:0] sum5;
   logic [8:0] diff9;
   logic [4:0] diff5;
   logic [7:0] res;
   logic       flag_n;
   logic       flag_h;
   logic       flag_c;
   logic       keep_zc;

   // nibble and byte carries for add, borrows for subtract
   assign sum9  = {1'b0, op_req.operand_a} + {1'b0, op_req.operand_b}
                + {8'd0, op_req.carry_in};
   assign sum5  = {1'b0, op_req.operand_a[3:0]} + {1'b0, op_req.operand_b[3:0]}
                + {4'd0, op_req.carry_in};
   assign diff9 = {1'b0, op_req.operand_a} - {1'b0, op_req.operand_b}
                - {8'd0, op_req.carry_in};
   assign diff5 = {1'b0, op_req.operand_a[3:0]} - {1'b0, op_req.operand_b[3:0]}
                - {4'd0, op_req.carry_in};

   always_comb begin
      res     = 8'd0;
      flag_n  = 1'b0;
      flag_h  = 1'b0;
      flag_c  = 1'b0;
      keep_zc = 1'b0;
      unique case (op_req.kind)
         OP_ADD: begin
            res    = sum9[7:0];
            flag_h = sum5[4];
            flag_c = sum9[8];
         end
         OP_SUBTRACT: begin
            res    = diff9[7:0];
            flag_n = 1'b1;
            flag_h = diff5[4];
            flag_c = diff9[8];
         end
         OP_AND: begin
            res    = op_req.operand_a & op_req.operand_b;
            flag_h = 1'b1;
         end
         OP_OR: begin
            res = op_req.operand_a | op_req.operand_b;
         end
         OP_XOR: begin
            res = op_req.operand_a ^ op_req.operand_b;
         end
         OP_SWAP: begin
            res = {op_req.operand_a[3:0], op_req.operand_a[7:4]};
         end
         OP_SHIFT: begin
            res    = {1'b0, op_req.operand_a[7:1]};
            flag_c = op_req.operand_a[0];
         end
         OP_COMPLEMENT: begin
            res     = ~op_req.operand_a;
            flag_n  = 1'b1;
            flag_h  = 1'b1;
            keep_zc = 1'b1;
         end
         default: begin
            res = 8'd0;
         end
      endcase
   end

   always_comb begin
      op_rsp.result    = res;
      op_rsp.flags_out = 8'd0;
      // complement passes z and c through from the incoming flags
      op_rsp.flags_out[FLAG_Z_BIT] = keep_zc ? op_req.flags_in[FLAG_Z_BIT]
                                             : (res == 8'd0);
      op_rsp.flags_out[FLAG_N_BIT] = flag_n;
      op_rsp.flags_out[FLAG_H_BIT] = flag_h;
      op_rsp.flags_out[FLAG_C_BIT] = keep_zc ? op_req.flags_in[FLAG_C_BIT] : flag_c;
   end

endmodule

### test/eight_bit_alu_with_flags_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_tb
// self-checking bench for the eight-bit alu with z/n/h/c flags
// ----------------------------------------------------------------------------
//
// operations are queued by the stimulus process and fed to the block by a
// falling-edge driver; a rising-edge monitor records every accepted item,
// predicts its result and flag byte, and checks each strobed result against
// the oldest prediction. directed corner items come first, then random items
// over several sender idle rates.
//
module eight_bit_alu_with_flags_tb;
   import alu8f_pkg::*;

   localparam int unsigned ITEMS_PER_PHASE = 282;
   localparam int unsigned NUM_PHASES      = 4;
   localparam int unsigned DRAIN_CYCLES    = 16;
   localparam int unsigned RUN_LIMIT_NS    = 200000;

   logic    clock;
   logic    reset;
   logic    start = 1'b0;
   req_type req   = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp;

   // operations waiting to be driven, and results predicted for taken items
   req_type op_items_q[$];
   rsp_type alu_results_q[$];

   int unsigned issued_count   = 0;
   int unsigned accepted_count = 0;
   int unsigned error_count    = 0;
   int unsigned idle_pct       = 0;

   // sender idle rate per random phase, in percent
   int unsigned phase_idle[NUM_PHASES] = '{0, 69, 0, 26};

   eight_bit_alu_with_flags dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // alu behavior: result byte and new flag byte for one operation
   function automatic rsp_type predict_alu(req_type item);
      logic [8:0] wide;
      logic [4:0] nib;
      rsp_type    r;
      r = '0;
      case (item.kind)
         OP_ADD: begin
            wide = {1'b0, item.operand_a} + {1'b0, item.operand_b}
                   + {8'd0, item.carry_in};
            nib  = {1'b0, item.operand_a[3:0]} + {1'b0, item.operand_b[3:0]}
                   + {4'd0, item.carry_in};
            r.result               = wide[7:0];
            r.flags_out[FLAG_H_BIT] = nib[4];
            r.flags_out[FLAG_C_BIT] = wide[8];
         end
         OP_SUBTRACT: begin
            // bit above the top of the difference is the borrow out
            wide = {1'b0, item.operand_a} - {1'b0, item.operand_b}
                   - {8'd0, item.carry_in};
            nib  = {1'b0, item.operand_a[3:0]} - {1'b0, item.operand_b[3:0]}
                   - {4'd0, item.carry_in};
            r.result               = wide[7:0];
            r.flags_out[FLAG_N_BIT] = 1'b1;
            r.flags_out[FLAG_H_BIT] = nib[4];
            r.flags_out[FLAG_C_BIT] = wide[8];
         end
         OP_AND: begin
            r.result               = item.operand_a & item.operand_b;
            r.flags_out[FLAG_H_BIT] = 1'b1;
         end
         OP_OR:   r.result = item.operand_a | item.operand_b;
         OP_XOR:  r.result = item.operand_a ^ item.operand_b;
         OP_SWAP: r.result = {item.operand_a[3:0], item.operand_a[7:4]};
         OP_SHIFT: begin
            r.result               = {1'b0, item.operand_a[7:1]};
            r.flags_out[FLAG_C_BIT] = item.operand_a[0];
         end
         default: begin
            // complement keeps z and c of the incoming flags
            r.result               = ~item.operand_a;
            r.flags_out[FLAG_N_BIT] = 1'b1;
            r.flags_out[FLAG_H_BIT] = 1'b1;
            r.flags_out[FLAG_Z_BIT] = item.flags_in[FLAG_Z_BIT];
            r.flags_out[FLAG_C_BIT] = item.flags_in[FLAG_C_BIT];
         end
      endcase
      if (item.kind != OP_COMPLEMENT) begin
         r.flags_out[FLAG_Z_BIT] = (r.result == 8'h00);
      end
      return r;
   endfunction

   // operand biased toward carry and zero corners
   function automatic logic [7:0] pick_operand();
      logic [7:0] corners[8];
      corners = '{8'h00, 8'hff, 8'h0f, 8'hf0, 8'h80, 8'h7f, 8'h01, 8'h10};
      if ($urandom_range(3) == 0) begin
         return corners[$urandom_range(7)];
      end
      return 8'($urandom);
   endfunction

   function automatic req_type random_op_item();
      req_type item;
      item.kind      = op_type'($urandom_range(7));
      item.operand_a = pick_operand();
      item.operand_b = pick_operand();
      item.carry_in  = 1'($urandom);
      item.flags_in  = 8'($urandom);
      return item;
   endfunction

   task automatic queue_op(op_type k, logic [7:0] a, logic [7:0] b, logic cin,
                           logic [7:0] fin);
      req_type item;
      item.kind      = k;
      item.operand_a = a;
      item.operand_b = b;
      item.carry_in  = cin;
      item.flags_in  = fin;
      op_items_q.push_back(item);
   endtask

   // sampled at the falling edge, away from the monitor's updates
   task automatic wait_all_done();
      while (op_items_q.size() != 0 || accepted_count != issued_count
             || alu_results_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // driver: hold the current item until taken, then maybe idle, then next
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && accepted_count != issued_count) begin
         // item still pending, keep it on the port
      end else if (op_items_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
         req          <= op_items_q.pop_front();
         start        <= 1'b1;
         issued_count <= issued_count + 1;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: check strobed results, then record the item taken at this edge
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (rsp_strobe === 1'b1) begin
         if (alu_results_q.size() == 0) begin
            $display("%0t: unexpected result, actual result %02h flags %02h",
                     $time, rsp.result, rsp.flags_out);
            error_count = error_count + 1;
         end else begin
            want = alu_results_q.pop_front();
            if (rsp.result !== want.result) begin
               $display("%0t: result mismatch, expected %02h, actual %02h",
                        $time, want.result, rsp.result);
               error_count = error_count + 1;
            end
            if (rsp.flags_out !== want.flags_out) begin
               $display("%0t: flags mismatch, expected %02h, actual %02h",
                        $time, want.flags_out, rsp.flags_out);
               error_count = error_count + 1;
            end
         end
      end
      if (start === 1'b1 && busy === 1'b0) begin
         alu_results_q.push_back(predict_alu(req));
         accepted_count <= accepted_count + 1;
      end
   end

   // stimulus and end of run
   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // add: zero, full carry, half carry from carry-in, top carry only
      queue_op(OP_ADD, 8'h00, 8'h00, 1'b0, 8'hff);
      queue_op(OP_ADD, 8'hff, 8'h01, 1'b0, 8'h00);
      queue_op(OP_ADD, 8'h0f, 8'h00, 1'b1, 8'h5a);
      queue_op(OP_ADD, 8'h80, 8'h80, 1'b0, 8'ha5);
      queue_op(OP_ADD, 8'hff, 8'hff, 1'b1, 8'h0f);
      // subtract: zero, full borrow, half borrow, borrow from carry-in
      queue_op(OP_SUBTRACT, 8'h00, 8'h00, 1'b0, 8'hff);
      queue_op(OP_SUBTRACT, 8'h00, 8'h01, 1'b0, 8'h00);
      queue_op(OP_SUBTRACT, 8'h10, 8'h01, 1'b0, 8'hf0);
      queue_op(OP_SUBTRACT, 8'h00, 8'h00, 1'b1, 8'h0f);
      queue_op(OP_SUBTRACT, 8'hff, 8'hff, 1'b1, 8'h33);
      // logic ops, zero and all-ones results
      queue_op(OP_AND, 8'hff, 8'hff, 1'b1, 8'h00);
      queue_op(OP_AND, 8'haa, 8'h55, 1'b0, 8'hff);
      queue_op(OP_OR, 8'h00, 8'h00, 1'b1, 8'hff);
      queue_op(OP_OR, 8'ha5, 8'h5a, 1'b0, 8'h00);
      queue_op(OP_XOR, 8'hff, 8'hff, 1'b0, 8'hff);
      queue_op(OP_XOR, 8'h0f, 8'hf0, 1'b1, 8'h0f);
      // swap and shift ignore operand b and carry-in
      queue_op(OP_SWAP, 8'h00, 8'hff, 1'b1, 8'hff);
      queue_op(OP_SWAP, 8'ha5, 8'h3c, 1'b0, 8'h00);
      queue_op(OP_SHIFT, 8'h01, 8'hff, 1'b1, 8'hff);
      queue_op(OP_SHIFT, 8'hff, 8'h00, 1'b0, 8'h00);
      // complement keeps z/c, low nibble of incoming flags must not leak
      queue_op(OP_COMPLEMENT, 8'hff, 8'h00, 1'b1, 8'hff);
      queue_op(OP_COMPLEMENT, 8'h00, 8'hff, 1'b0, 8'h00);
      queue_op(OP_COMPLEMENT, 8'h5a, 8'h12, 1'b1, 8'h0f);
      queue_op(OP_COMPLEMENT, 8'ha5, 8'h00, 1'b0, 8'h90);
      wait_all_done();

      for (int p = 0; p < NUM_PHASES; p++) begin
         idle_pct = phase_idle[p];
         repeat (ITEMS_PER_PHASE) op_items_q.push_back(random_op_item());
         wait_all_done();
      end

      // catch any stray strobe after the last expected result
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (alu_results_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  alu_results_q.size());
         error_count = error_count + 1;
      end

      if (error_count == 0) begin
         $display("PASS eight_bit_alu_with_flags");
      end else begin
         $display("FAIL eight_bit_alu_with_flags");
      end
      $finish;
   end

   // hard stop if the run hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL eight_bit_alu_with_flags");
      $finish;
   end

endmodule
